// ===== hw/rtl/tqd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the three-queue tick task dispatcher.
// No dependencies.
package tqd_pkg;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_TICK = 2'd1,
		KIND_PULL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_FULL       = 2'd1,
		ST_DISPATCHED = 2'd2,
		ST_NONE       = 2'd3
	} status_t;

	localparam logic [1:0] Q_SLOW   = 2'd0;
	localparam logic [1:0] Q_MEDIUM = 2'd1;
	localparam logic [1:0] Q_FAST   = 2'd2;

	// Result of one transaction, waiting for the RAM read data.
	typedef struct packed {
		status_t    status;
		logic       from_ram;
		logic [1:0] q;
	} pend_t;

endpackage

// ===== hw/rtl/tqd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: push / tick / pull items with valid-ready handshake.
// No dependencies.
interface tqd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] queue_sel;
	logic [7:0] task_id;

	modport source (output valid, output kind, output queue_sel, output task_id, input ready);
	modport sink (input valid, input kind, input queue_sel, input task_id, output ready);
endinterface

// ===== hw/rtl/tqd_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one status / task result per item, valid-ready handshake.
// No dependencies.
interface tqd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] out_task;

	modport source (output valid, output status, output out_task, input ready);
	modport sink (input valid, input status, input out_task, output ready);
endinterface

// ===== hw/rtl/tqd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/tqd_ctrl.sv =====
`timescale 1ns / 1ps
// Queue control: read/write positions, tick phases, push/pull decision
// and RAM commands. Depends on tqd_pkg.
module tqd_ctrl
	import tqd_pkg::*;
#(
	parameter int SLOW_DEPTH   = 16,
	parameter int MEDIUM_DEPTH = 16,
	parameter int FAST_DEPTH   = 16,
	parameter int TASK_BITS    = 8,
	parameter int PTR_W        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [1:0]           kind,
	input  logic [1:0]           queue_sel,
	input  logic [7:0]           task_id,
	output logic [2:0]           ram_we,
	output logic [2:0]           ram_re,
	output logic [PTR_W-1:0]     ram_waddr,
	output logic [PTR_W-1:0]     ram_raddr,
	output logic [TASK_BITS-1:0] ram_wdata,
	output pend_t                pend
);

	localparam logic [PTR_W-1:0] LAST [3] = '{
		PTR_W'(SLOW_DEPTH - 1), PTR_W'(MEDIUM_DEPTH - 1), PTR_W'(FAST_DEPTH - 1)
	};

	logic [PTR_W-1:0] wp_q [3];
	logic [PTR_W-1:0] rp_q [3];
	logic [2:0]       ph_q [3];

	logic                 q_ok;
	logic [1:0]           qi;
	logic [PTR_W-1:0]     wp_c, rp_c, wp_nxt, rp_nxt;
	logic [2:0]           ph_c;
	logic                 full, empty, pull_req;
	logic                 do_push, do_pull, do_tick;
	logic [TASK_BITS+7:0] id_wide;

	assign id_wide   = {{TASK_BITS{1'b0}}, task_id};
	assign ram_wdata = id_wide[TASK_BITS-1:0];

	always_comb begin
		q_ok     = (queue_sel == Q_SLOW) || (queue_sel == Q_MEDIUM) || (queue_sel == Q_FAST);
		qi       = q_ok ? queue_sel : Q_SLOW;
		wp_c     = wp_q[qi];
		rp_c     = rp_q[qi];
		ph_c     = ph_q[qi];
		wp_nxt   = (wp_c == LAST[qi]) ? '0 : wp_c + 1'b1;
		rp_nxt   = (rp_c == LAST[qi]) ? '0 : rp_c + 1'b1;
		full     = (wp_nxt == rp_c);
		empty    = (wp_c == rp_c);
		pull_req = 1'b0;
		do_push  = 1'b0;
		do_tick  = 1'b0;
		pend.status   = ST_NONE;
		pend.from_ram = 1'b0;
		pend.q        = qi;
		unique case (kind_t'(kind))
			KIND_PUSH: begin
				if (q_ok && !full) begin
					pend.status = ST_ACCEPTED;
					do_push     = 1'b1;
				end else begin
					pend.status = ST_FULL;
				end
			end
			KIND_TICK: begin
				// fast queue pulls on phase 0, the others on phases 1..7
				do_tick  = q_ok;
				pull_req = q_ok && ((qi == Q_FAST) ? (ph_c == 3'd0) : (ph_c != 3'd0));
			end
			KIND_PULL: pull_req = q_ok;
			default: pull_req = 1'b0;
		endcase
		do_pull = pull_req && !empty;
		if (do_pull) begin
			pend.status   = ST_DISPATCHED;
			pend.from_ram = 1'b1;
		end
		ram_we    = '0;
		ram_re    = '0;
		ram_we[qi] = fire && do_push;
		ram_re[qi] = fire && do_pull;
		ram_waddr = wp_c;
		ram_raddr = rp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
				ph_q[i] <= '0;
			end
		end else if (fire) begin
			if (do_push) begin
				wp_q[qi] <= wp_nxt;
			end
			if (do_pull) begin
				rp_q[qi] <= rp_nxt;
			end
			if (do_tick) begin
				ph_q[qi] <= ph_c + 3'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/three_queue_tick_task_dispatcher_top.sv =====
`timescale 1ns / 1ps
// Top level of the three-queue tick task dispatcher.
// Depends on tqd_pkg, tqd_in_if, tqd_out_if, tqd_ram, tqd_ctrl.
//
//  channel  | dir | payload                       | handshake
//  ---------+-----+-------------------------------+-------------
//  items    | in  | kind, queue_sel, task_id      | valid/ready
//  results  | out | status, out_task              | valid/ready
//
// One transaction in, one result out: the accept cycle updates
// positions/phases and issues the queue RAM access, and the pending stage
// then moves the registered RAM read data into the output register. An item
// can be accepted every cycle while the result side keeps up. Reset clears
// positions and phases at once; queue RAM contents are never cleared. A
// stalled result holds the pending stage, which blocks the input until it moves.
module three_queue_tick_task_dispatcher_top
	import tqd_pkg::*;
#(
	parameter int SLOW_DEPTH   = 16,
	parameter int MEDIUM_DEPTH = 16,
	parameter int FAST_DEPTH   = 16,
	parameter int TASK_BITS    = 8
) (
	input logic         clk,
	input logic         arst_n,
	tqd_in_if.sink      items,
	tqd_out_if.source   results
);

	localparam int MAX_SM    = (SLOW_DEPTH > MEDIUM_DEPTH) ? SLOW_DEPTH : MEDIUM_DEPTH;
	localparam int MAX_DEPTH = (MAX_SM > FAST_DEPTH) ? MAX_SM : FAST_DEPTH;
	localparam int PTR_W     = $clog2(MAX_DEPTH);
	localparam int SLOW_AW   = $clog2(SLOW_DEPTH);
	localparam int MEDIUM_AW = $clog2(MEDIUM_DEPTH);
	localparam int FAST_AW   = $clog2(FAST_DEPTH);

	logic                 fire;
	logic [2:0]           ram_we, ram_re;
	logic [PTR_W-1:0]     ram_waddr, ram_raddr;
	logic [TASK_BITS-1:0] ram_wdata;
	logic [TASK_BITS-1:0] rdata_slow, rdata_medium, rdata_fast, rdata_sel;
	logic [TASK_BITS+7:0] rdata_wide;
	pend_t                pend;

	logic       v_s1;
	pend_t      pend_s1;
	logic       s1_adv;
	logic       out_v_q;
	status_t    status_q;
	logic [7:0] task_q;

	assign s1_adv      = v_s1 && (!out_v_q || results.ready);
	assign items.ready = !v_s1 || s1_adv;
	assign fire        = items.valid && items.ready;

	tqd_ctrl #(
		.SLOW_DEPTH   (SLOW_DEPTH),
		.MEDIUM_DEPTH (MEDIUM_DEPTH),
		.FAST_DEPTH   (FAST_DEPTH),
		.TASK_BITS    (TASK_BITS),
		.PTR_W        (PTR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.kind      (items.kind),
		.queue_sel (items.queue_sel),
		.task_id   (items.task_id),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.ram_wdata (ram_wdata),
		.pend      (pend)
	);

	tqd_ram #(.WIDTH(TASK_BITS), .DEPTH(SLOW_DEPTH)) u_ram_slow (
		.clk   (clk),
		.we    (ram_we[Q_SLOW]),
		.waddr (ram_waddr[SLOW_AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re[Q_SLOW]),
		.raddr (ram_raddr[SLOW_AW-1:0]),
		.rdata (rdata_slow)
	);

	tqd_ram #(.WIDTH(TASK_BITS), .DEPTH(MEDIUM_DEPTH)) u_ram_medium (
		.clk   (clk),
		.we    (ram_we[Q_MEDIUM]),
		.waddr (ram_waddr[MEDIUM_AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re[Q_MEDIUM]),
		.raddr (ram_raddr[MEDIUM_AW-1:0]),
		.rdata (rdata_medium)
	);

	tqd_ram #(.WIDTH(TASK_BITS), .DEPTH(FAST_DEPTH)) u_ram_fast (
		.clk   (clk),
		.we    (ram_we[Q_FAST]),
		.waddr (ram_waddr[FAST_AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re[Q_FAST]),
		.raddr (ram_raddr[FAST_AW-1:0]),
		.rdata (rdata_fast)
	);

	// A push lands in the RAM at the accept edge, so a pull of the same
	// entry one transaction later already reads the new value.
	always_comb begin
		unique case (pend_s1.q)
			Q_SLOW:   rdata_sel = rdata_slow;
			Q_MEDIUM: rdata_sel = rdata_medium;
			default:  rdata_sel = rdata_fast;
		endcase
		rdata_wide = {8'd0, rdata_sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (items.ready) begin
				v_s1 <= fire;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_s1 <= pend;
		end
		if (s1_adv) begin
			status_q <= pend_s1.status;
			task_q   <= pend_s1.from_ram ? rdata_wide[7:0] : 8'd0;
		end
	end

	assign results.valid    = out_v_q;
	assign results.status   = status_q;
	assign results.out_task = task_q;

	a_one_ram_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ram_we, ram_re}))
		else $error("more than one queue RAM access in a cycle");

	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |-> (ram_re == 3'b000))
		else $error("RAM read issued while pending result is stalled");

	a_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q != ST_DISPATCHED) |-> (task_q == 8'd0))
		else $error("task id shown without a dispatch");

	a_ram_read_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re != 3'b000) |=> (v_s1 && pend_s1.from_ram))
		else $error("RAM read not followed by a pending dispatch");

endmodule

// ===== test/tb_three_queue_tick_task_dispatcher_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for three_queue_tick_task_dispatcher_top.
// Depends on tqd_pkg, tqd_in_if, tqd_out_if and the dispatcher RTL.
module tb_three_queue_tick_task_dispatcher_top;
	import tqd_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam logic [1:0] Q_NONE       = 2'd3;
	localparam int         RAND_ITEMS   = 1250;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         HOLD_CYCLES  = 80;
	localparam int         DIR_ROWS     = 24;

	typedef struct packed {
		status_t    status;
		logic [7:0] disp_task;
	} dispatch_res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] qsel;
		logic [7:0] id;
		logic       typed;
		status_t    st;
		logic [7:0] tk;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tqd_in_if  items_if ();
	tqd_out_if results_if ();

	three_queue_tick_task_dispatcher_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: rings, positions and tick phases per queue
	logic [7:0] ring_mem [3][16];
	logic [3:0] wr_pos [3];
	logic [3:0] rd_pos [3];
	logic [2:0] tick_phase [3];

	dispatch_res_t dispatch_q [$];

	int cycle_count = 0;
	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	int rand_items = 0;
	int burst_left = 0;
	int hold_reqs = 0;
	int n_accept = 0;
	int n_full = 0;
	int n_disp = 0;
	int n_none = 0;

	// Directed rows: typed expectations where the outcome is obvious, predicted where typed is 0
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{KIND_PULL,    Q_SLOW,   8'h00, 1'b1, ST_NONE,       8'h00},
		'{KIND_TICK,    Q_FAST,   8'h00, 1'b1, ST_NONE,       8'h00},
		'{KIND_TICK,    Q_SLOW,   8'hFF, 1'b1, ST_NONE,       8'h00},
		'{KIND_PUSH,    Q_SLOW,   8'h00, 1'b1, ST_ACCEPTED,   8'h00},
		'{KIND_PUSH,    Q_SLOW,   8'hFF, 1'b1, ST_ACCEPTED,   8'h00},
		'{KIND_TICK,    Q_SLOW,   8'h00, 1'b1, ST_DISPATCHED, 8'h00},
		'{KIND_PULL,    Q_SLOW,   8'h55, 1'b1, ST_DISPATCHED, 8'hFF},
		'{KIND_PULL,    Q_SLOW,   8'h00, 1'b1, ST_NONE,       8'h00},
		'{KIND_PUSH,    Q_NONE,   8'h3C, 1'b1, ST_FULL,       8'h00},
		'{KIND_TICK,    Q_NONE,   8'hAA, 1'b1, ST_NONE,       8'h00},
		'{KIND_PULL,    Q_NONE,   8'hFF, 1'b1, ST_NONE,       8'h00},
		'{KIND_IGNORED, Q_SLOW,   8'h77, 1'b1, ST_NONE,       8'h00},
		'{KIND_IGNORED, Q_FAST,   8'hFF, 1'b1, ST_NONE,       8'h00},
		'{KIND_PUSH,    Q_MEDIUM, 8'hA5, 1'b1, ST_ACCEPTED,   8'h00},
		'{KIND_PUSH,    Q_FAST,   8'h5A, 1'b1, ST_ACCEPTED,   8'h00},
		'{KIND_TICK,    Q_FAST,   8'h00, 1'b1, ST_NONE,       8'h00},
		'{KIND_PULL,    Q_FAST,   8'h00, 1'b1, ST_DISPATCHED, 8'h5A},
		'{KIND_TICK,    Q_MEDIUM, 8'h00, 1'b1, ST_NONE,       8'h00},
		'{KIND_TICK,    Q_MEDIUM, 8'h0F, 1'b1, ST_DISPATCHED, 8'hA5},
		'{KIND_PUSH,    Q_MEDIUM, 8'h81, 1'b0, ST_NONE,       8'h00},
		'{KIND_PUSH,    Q_FAST,   8'h7E, 1'b0, ST_NONE,       8'h00},
		'{KIND_PULL,    Q_MEDIUM, 8'h00, 1'b0, ST_NONE,       8'h00},
		'{KIND_TICK,    Q_SLOW,   8'h00, 1'b0, ST_NONE,       8'h00},
		'{KIND_PULL,    Q_FAST,   8'h00, 1'b0, ST_NONE,       8'h00}
	};

	function automatic dispatch_res_t model_dispatch(input logic [1:0] kind,
			input logic [1:0] qsel, input logic [7:0] id);
		dispatch_res_t r;
		logic          pull_now;
		int            qi;
		r.status = ST_NONE;
		r.disp_task = 8'h00;
		pull_now = 1'b0;
		qi = int'(qsel);
		if (kind == KIND_PUSH) begin
			if (qsel == Q_NONE || 4'(wr_pos[qi] + 4'd1) == rd_pos[qi]) begin
				r.status = ST_FULL;
			end else begin
				ring_mem[qi][wr_pos[qi]] = id;
				wr_pos[qi] = 4'(wr_pos[qi] + 4'd1);
				r.status = ST_ACCEPTED;
			end
		end else if (kind == KIND_TICK) begin
			if (qsel != Q_NONE) begin
				// fast queue pulls on phase 0 only, the others on phases 1 to 7
				pull_now = (qsel == Q_FAST) ? (tick_phase[qi] == 3'd0) : (tick_phase[qi] != 3'd0);
				tick_phase[qi] = 3'(tick_phase[qi] + 3'd1);
			end
		end else if (kind == KIND_PULL) begin
			pull_now = (qsel != Q_NONE);
		end
		if (pull_now && rd_pos[qi] != wr_pos[qi]) begin
			r.status = ST_DISPATCHED;
			r.disp_task = ring_mem[qi][rd_pos[qi]];
			rd_pos[qi] = 4'(rd_pos[qi] + 4'd1);
		end
		return r;
	endfunction

	// Offer one transaction from a falling edge, return at the falling edge after acceptance.
	task automatic offer(input logic [1:0] k, input logic [1:0] q, input logic [7:0] id,
			input logic typed, input dispatch_res_t typed_res);
		dispatch_res_t pred;
		items_if.valid = 1'b1;
		items_if.kind = k;
		items_if.queue_sel = q;
		items_if.task_id = id;
		do @(posedge clk); while (!items_if.ready);
		pred = model_dispatch(k, q, id);
		dispatch_q.push_back(typed ? typed_res : pred);
		sent++;
		@(negedge clk);
	endtask

	// Sender bursts: random lengths, random gaps, now and then a long unbroken run
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			items_if.valid = 1'b0;
			items_if.kind = 2'($urandom_range(0, 3));
			items_if.queue_sel = 2'($urandom_range(0, 3));
			items_if.task_id = 8'($urandom_range(0, 255));
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	initial begin : stimulus
		dispatch_res_t typed_res;
		int            mode;
		int            len;
		int            sub;
		int            roll;
		logic [1:0]    target;
		logic [1:0]    k;
		logic [1:0]    q;
		logic [7:0]    id;
		items_if.valid = 1'b0;
		items_if.kind = KIND_PUSH;
		items_if.queue_sel = Q_SLOW;
		items_if.task_id = 8'h00;
		for (int i = 0; i < 3; i++) begin
			wr_pos[i] = 4'd0;
			rd_pos[i] = 4'd0;
			tick_phase[i] = 3'd0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			typed_res.status = dir_rows[i].st;
			typed_res.disp_task = dir_rows[i].tk;
			pace();
			offer(dir_rows[i].kind, dir_rows[i].qsel, dir_rows[i].id, dir_rows[i].typed,
				typed_res);
		end

		// Episodes aimed at one queue: fill, drain, tick runs, or a free mix
		while (rand_items < RAND_ITEMS) begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(4, 40);
			target = 2'($urandom_range(0, 2));
			for (int n = 0; n < len && rand_items < RAND_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				sub = $urandom_range(0, 99);
				id = 8'($urandom_range(0, 255));
				q = target;
				if (roll < 4) begin
					k = KIND_IGNORED;
					q = 2'($urandom_range(0, 3));
				end else if (roll < 8) begin
					k = 2'($urandom_range(0, 2));
					q = Q_NONE;
				end else begin
					case (mode)
						0: k = (sub < 85) ? KIND_PUSH : ((sub < 93) ? KIND_TICK : KIND_PULL);
						1: k = (sub < 25) ? KIND_PUSH : ((sub < 60) ? KIND_TICK : KIND_PULL);
						2: k = (sub < 20) ? KIND_PUSH : KIND_TICK;
						default: begin
							k = 2'($urandom_range(0, 2));
							q = 2'($urandom_range(0, 2));
						end
					endcase
				end
				pace();
				offer(k, q, id, 1'b0, '0);
				rand_items++;
				if (rand_items == 300 || rand_items == 800)
					hold_reqs <= hold_reqs + 1;
				if (rand_items == 550 || rand_items == 1050) begin
					items_if.valid = 1'b0;
					do @(negedge clk); while (dispatch_q.size() != 0);
				end
			end
		end

		items_if.valid = 1'b0;
		do @(negedge clk); while (dispatch_q.size() != 0);
		repeat (10) @(negedge clk);

		$display("Sent %0d transactions (%0d directed), %0d results checked, %0d mismatches.",
			sent, DIR_ROWS, checked, mismatches);
		$display("Results seen: %0d accepted, %0d full, %0d dispatched, %0d nothing dispatched.",
			n_accept, n_full, n_disp, n_none);
		if (mismatches == 0 && dispatch_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Result side: stall patterns, plus long hold-offs asked for by the sender
	initial begin : result_sink
		int hold_left;
		int holds_done;
		int mode;
		int mode_left;
		hold_left = 0;
		holds_done = 0;
		mode = 0;
		mode_left = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0: results_if.ready = 1'b1;
					1: results_if.ready = ($urandom_range(0, 3) != 0);
					2: results_if.ready = 1'($urandom_range(0, 1));
					default: results_if.ready = ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		dispatch_res_t e;
		if (arst_n && results_if.valid && results_if.ready) begin
			checked++;
			case (results_if.status)
				ST_ACCEPTED:   n_accept++;
				ST_FULL:       n_full++;
				ST_DISPATCHED: n_disp++;
				default:       n_none++;
			endcase
			if (dispatch_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no transaction pending: status %0d task %0h",
						$realtime, results_if.status, results_if.out_task);
				mismatches++;
			end else begin
				e = dispatch_q.pop_front();
				if (results_if.status !== e.status || results_if.out_task !== e.disp_task) begin
					if (mismatches < 10)
						$display("%0t: mismatch: status exp %0d got %0d, task exp %0h got %0h",
							$realtime, e.status, results_if.status, e.disp_task,
							results_if.out_task);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
				dispatch_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
